>>> design/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  // Width of the external words; the operand width may be narrower.
  localparam int FIELD_BITS = 63;
  localparam int OPERAND_BITS_DEFAULT = 63;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS = 2'd1;

  // Status of the shared modular multiplier as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

>>> design/modular_exponentiation_core.sv
// With a zero modulus or a zero exponent the core goes from S_IDLE straight to S_DONE, with no
// multiplier pass. Otherwise the bit-serial modular multiplier (W = OPERAND_BITS) makes one pass
// to reduce the base, then each exponent bit costs a pass for the multiply when set and a pass
// for the squaring unless no higher bit remains. in_stall is high from acceptance until the
// result is registered. Reset (synchronous, rst high) sets exponent to 0, modulus to 1 and
// empties the output.
`default_nettype none

module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [FIELD_BITS-1:0]     cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [FIELD_BITS-1:0]     base,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [FIELD_BITS-1:0]          power,
  output logic                           bad_modulus
);

  localparam int W = OPERAND_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]   state;
  logic [2:0]   state_next;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;
  logic [W-1:0] e_work;
  logic [W-1:0] e_work_next;
  logic [W-1:0] sq;
  logic [W-1:0] sq_next;
  logic [W-1:0] prod;
  logic [W-1:0] prod_next;
  logic         bad;
  logic         bad_next;
  logic [W-1:0] power_reg;
  logic         out_load;

  logic         mm_start;
  logic [W-1:0] mm_x;
  logic [W-1:0] mm_y;
  logic [W-1:0] mm_result;
  mm_status_t   mm_stat;

  mexp_mulmod #(.W(W)) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (modulus),
    .result (mm_result),
    .status (mm_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus <= W'(1);
    end else if (cfg_write) begin
      if (cfg_index == REG_EXPONENT) begin
        exponent <= cfg_data[W-1:0];
      end else if (cfg_index == REG_MODULUS) begin
        modulus <= cfg_data[W-1:0];
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    e_work_next = e_work;
    sq_next = sq;
    prod_next = prod;
    bad_next = bad;
    mm_start = 1'b0;
    mm_x = sq;
    mm_y = sq;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (modulus == '0) begin
            prod_next = '0;
            bad_next = 1'b1;
            state_next = S_DONE;
          end else if (exponent == '0) begin
            prod_next = W'(1);
            bad_next = 1'b0;
            state_next = S_DONE;
          end else begin
            // Reduce the base as 1 * base mod m on the shared multiplier.
            bad_next = 1'b0;
            e_work_next = exponent;
            prod_next = (modulus == W'(1)) ? '0 : W'(1);
            mm_start = 1'b1;
            mm_x = W'(1);
            mm_y = base[W-1:0];
            state_next = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_stat.done) begin
          sq_next = mm_result;
          mm_start = 1'b1;
          mm_y = mm_result;
          if (e_work[0]) begin
            mm_x = prod;
            state_next = S_MUL;
          end else begin
            mm_x = mm_result;
            state_next = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mm_stat.done) begin
          prod_next = mm_result;
          if (e_work[W-1:1] == '0) begin
            state_next = S_DONE;
          end else begin
            mm_start = 1'b1;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_stat.done) begin
          sq_next = mm_result;
          e_work_next = e_work >> 1;
          mm_start = 1'b1;
          mm_y = mm_result;
          if (e_work[1]) begin
            mm_x = prod;
            state_next = S_MUL;
          end else begin
            mm_x = mm_result;
            state_next = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    e_work <= e_work_next;
    sq <= sq_next;
    prod <= prod_next;
    bad <= bad_next;
  end

  // The output word is held until taken; a finished result waits in S_DONE.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      power_reg <= prod;
      bad_modulus <= bad;
    end
  end

  assign power = FIELD_BITS'(power_reg);

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == S_RED || state == S_MUL || state == S_SQR))
    else $error("multiplier finished outside a run");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_modulus |-> power == '0)
    else $error("error word carries a nonzero power");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  a_run_needs_modulus: assert property (@(posedge clk) disable iff (rst)
    mm_stat.busy |-> modulus != '0)
    else $error("multiplier running with zero modulus");

endmodule

`default_nettype wire

>>> design/mexp_mulmod.sv
`default_nettype none

// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Each step forms 2*acc + bit*x, which stays below 3*m, and removes 2*m, m or nothing.
module mexp_mulmod import mexp_pkg::*; #(
  parameter int W = OPERAND_BITS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] x,
  input  wire logic [W-1:0] y,
  input  wire logic [W-1:0] m,
  output logic [W-1:0]      result,
  output mm_status_t        status
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  acc_next;
  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [W-1:0]  mr;
  logic [CW-1:0] cnt;
  logic          done;

  logic [W+1:0] t;
  logic [W+1:0] m1;
  logic [W+1:0] m2;

  always_comb begin
    t = {1'b0, acc, 1'b0} + (yr[W-1] ? {2'b00, xr} : '0);
    m1 = {2'b00, mr};
    m2 = {1'b0, mr, 1'b0};
    if (t >= m2) begin
      acc_next = W'(t - m2);
    end else if (t >= m1) begin
      acc_next = W'(t - m1);
    end else begin
      acc_next = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr <= x;
      yr <= y;
      mr <= m;
    end else if (cnt != '0) begin
      acc <= acc_next;
      yr <= yr << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;
  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

`default_nettype wire

>>> test/modular_exponentiation_core_tb.sv
`default_nettype none

module modular_exponentiation_core_tb;
  import mexp_pkg::*;

  localparam int OPERAND_BITS = OPERAND_BITS_DEFAULT;
  localparam logic [FIELD_BITS-1:0] WORD_ONE = 1;
  localparam logic [FIELD_BITS-1:0] WORD_MAX = '1;
  localparam logic [FIELD_BITS-1:0] OPERAND_MASK =
      (OPERAND_BITS >= FIELD_BITS) ? WORD_MAX : ((WORD_ONE << OPERAND_BITS) - WORD_ONE);
  // Indexes that decode to no register.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [FIELD_BITS-1:0] power;
    logic                  bad;
  } modexp_result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_EXPONENT;
  logic [FIELD_BITS-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [FIELD_BITS-1:0]     base = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [FIELD_BITS-1:0]     power;
  logic                      bad_modulus;

  modular_exponentiation_core #(
    .OPERAND_BITS(OPERAND_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .base(base),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power(power),
    .bad_modulus(bad_modulus)
  );

  logic [FIELD_BITS-1:0] model_exponent = '0;
  logic [FIELD_BITS-1:0] model_modulus = WORD_ONE;

  logic [FIELD_BITS-1:0] pending_bases[$];
  modexp_result_t        expected_results[$];

  logic        in_accepted = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bad_results = 0;
  int unsigned settings_used = 1;
  int unsigned fail_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [FIELD_BITS-1:0] rand_word();
    return FIELD_BITS'({$urandom(), $urandom()});
  endfunction

  // Exact (x * y) mod m through a double-width product.
  function automatic logic [FIELD_BITS-1:0] mod_product(input logic [FIELD_BITS-1:0] x,
                                                        input logic [FIELD_BITS-1:0] y,
                                                        input logic [FIELD_BITS-1:0] m);
    logic [2*FIELD_BITS-1:0] wide;
    wide = {{FIELD_BITS{1'b0}}, x} * {{FIELD_BITS{1'b0}}, y};
    wide = wide % {{FIELD_BITS{1'b0}}, m};
    return wide[FIELD_BITS-1:0];
  endfunction

  function automatic modexp_result_t predict_power(input logic [FIELD_BITS-1:0] b);
    logic [FIELD_BITS-1:0] m;
    logic [FIELD_BITS-1:0] e;
    logic [FIELD_BITS-1:0] sq;
    logic [FIELD_BITS-1:0] prod;
    modexp_result_t        r;
    m = model_modulus & OPERAND_MASK;
    e = model_exponent & OPERAND_MASK;
    if (m == '0) begin
      r.power = '0;
      r.bad = 1'b1;
    end else begin
      sq = (b & OPERAND_MASK) % m;
      // A zero exponent leaves the product at 1 even for a modulus of 1.
      prod = WORD_ONE;
      while (e != '0) begin
        if (e[0]) begin
          prod = mod_product(prod % m, sq, m);
        end
        sq = mod_product(sq, sq, m);
        e = e >> 1;
      end
      r.power = prod;
      r.bad = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_ONE;
      2, 3: return FIELD_BITS'($urandom_range(2, 64));
      4: return WORD_ONE << $urandom_range(0, FIELD_BITS - 1);
      5: return WORD_MAX;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_modulus();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return WORD_ONE;
      2: return FIELD_BITS'(2);
      3, 4: return FIELD_BITS'($urandom_range(3, 1000));
      5: return WORD_MAX;
      6: return WORD_ONE << $urandom_range(1, FIELD_BITS - 1);
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_base(input logic [FIELD_BITS-1:0] m);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WORD_MAX;
      2: return FIELD_BITS'($urandom_range(0, 1000));
      3: return m - WORD_ONE;
      4: return m;
      default: return rand_word();
    endcase
  endfunction

  // Both sides are checked here so that a pop and a push at one edge stay ordered.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: power %h bad_modulus %b",
                 power, bad_modulus);
          fail_count++;
        end else begin
          modexp_result_t want;
          want = expected_results.pop_front();
          results_checked++;
          if (want.bad) bad_results++;
          if (power !== want.power) begin
            $error("power mismatch: expected %h, actual %h", want.power, power);
            fail_count++;
          end
          if (bad_modulus !== want.bad) begin
            $error("bad_modulus mismatch: expected %b, actual %b", want.bad, bad_modulus);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_power(base));
      end
    end
    in_accepted <= !rst && in_valid && !in_stall;
  end

  // Sender: bursts of words with random gaps in between.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bases.size() != 0) begin
        base <= pending_bases.pop_front();
        in_valid <= 1'b1;
        words_sent++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: runs of stall and free cycles, now and then a long free stretch.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(1, 40);
        end
        4, 5, 6, 7: begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(1, 15);
        end
        default: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(200, 2000);
        end
      endcase
    end else begin
      stall_left--;
    end
  end

  task automatic wait_idle();
    while (pending_bases.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [FIELD_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_EXPONENT: model_exponent = val & OPERAND_MASK;
      REG_MODULUS: model_modulus = val & OPERAND_MASK;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic apply_setting(input logic [FIELD_BITS-1:0] e, input logic [FIELD_BITS-1:0] m);
    wait_idle();
    write_reg(REG_EXPONENT, e);
    write_reg(REG_MODULUS, m);
    end_writes();
  endtask

  initial begin
    logic [FIELD_BITS-1:0] m;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: exponent 0 with modulus 1 must still give 1.
    pending_bases.push_back('0);
    pending_bases.push_back(WORD_MAX);
    pending_bases.push_back(WORD_ONE);
    pending_bases.push_back(rand_word());

    // Zero modulus raises the error flag whatever the exponent.
    apply_setting(rand_word() | WORD_ONE, '0);
    pending_bases.push_back('0);
    pending_bases.push_back(WORD_MAX);
    wait_idle();
    write_reg(REG_EXPONENT, '0);
    end_writes();
    pending_bases.push_back(rand_word());

    // Writes to undecoded indexes must leave both registers alone.
    wait_idle();
    write_reg(REG_SPARE_A, WORD_MAX);
    write_reg(REG_SPARE_B, rand_word());
    end_writes();
    pending_bases.push_back(rand_word());

    // Widest exponent and modulus: the slowest case.
    apply_setting(WORD_MAX, WORD_MAX);
    pending_bases.push_back(WORD_MAX);
    pending_bases.push_back(WORD_MAX - WORD_ONE);
    pending_bases.push_back(FIELD_BITS'(2));

    apply_setting('0, rand_word() | (WORD_ONE << (FIELD_BITS - 1)));
    pending_bases.push_back(rand_word());
    apply_setting(FIELD_BITS'(3), WORD_ONE);
    pending_bases.push_back(FIELD_BITS'(7));
    apply_setting(WORD_ONE, rand_word() | WORD_ONE);
    pending_bases.push_back(WORD_MAX);
    apply_setting(WORD_ONE << (FIELD_BITS - 1), FIELD_BITS'(2));
    pending_bases.push_back(FIELD_BITS'(3));
    pending_bases.push_back(FIELD_BITS'(4));

    // Random settings, each followed by a batch of bases.
    for (int phase = 0; phase < 8; phase++) begin
      m = pick_modulus();
      apply_setting(pick_exponent(), m);
      for (int k = 0; k < 12; k++) begin
        pending_bases.push_back(pick_base(m));
      end
    end

    wait_idle();
    repeat (64) @(posedge clk);
    $display("Sent %0d bases under %0d register settings, checked %0d results.",
             words_sent, settings_used, results_checked);
    $display("%0d results flagged a zero modulus; %0d failures seen.", bad_results, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation_core.sv
test/modular_exponentiation_core_tb.sv
